FILE: design/sfrd_pkg.sv
// Shared types and constants for the serial frame receive deframer.
`timescale 1ns / 1ps

package sfrd_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;  // byte + index, padded to whole bytes

  localparam logic [SAMPLE_W-1:0] START_MASK    = 8'b1111_1100;
  localparam logic [SAMPLE_W-1:0] LOW_MASK      = 8'b0000_0011;
  localparam logic [SAMPLE_W-1:0] START_PATTERN = 8'b1000_0100;
  localparam logic [INDEX_W-1:0]  BASE_LENGTH   = 11'd5;
  localparam logic [TICKS_W-1:0]  TIMEOUT_RESET = 16'd5000;
  localparam logic [TICKS_W-1:0]  TICKS_MAX     = 16'hFFFF;

  // Operation codes carried on the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_ARM    = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  // Result status codes carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_BYTE     = 3'd0,
    ST_SUM_OK   = 3'd1,
    ST_SUM_BAD  = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_SYNC_ERR = 3'd4
  } status_t;

  // Receiver state, one-hot
  typedef enum logic [2:0] {
    RX_INACTIVE = 3'b001,
    RX_HUNT     = 3'b010,
    RX_DATA     = 3'b100
  } rx_state_t;

  // One result handed from the core to the output stage
  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [BYTE_W-1:0]   pbyte;
    logic [INDEX_W-1:0]  index;
  } result_t;

endpackage

FILE: design/sfrd_core.sv
// Deframer state and per-transaction result logic.
`timescale 1ns / 1ps

module sfrd_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [sfrd_pkg::OP_W-1:0] op,
  input  logic [sfrd_pkg::SAMPLE_W-1:0] sample,
  input  logic                      cfg_we,
  input  logic [sfrd_pkg::TICKS_W-1:0] cfg_data,
  output sfrd_pkg::result_t         res
);
  import sfrd_pkg::*;

  rx_state_t             state, state_next;
  logic [SAMPLE_W-1:0]   prev_sample, prev_sample_next;
  logic [BYTE_W-1:0]     running_xor, running_xor_next;
  logic [INDEX_W-1:0]    byte_count, byte_count_next;
  logic [INDEX_W-1:0]    frame_length, frame_length_next;
  logic [TICKS_W-1:0]    idle_ticks, idle_ticks_next;
  logic [TICKS_W-1:0]    timeout_ticks;

  logic [TICKS_W-1:0]    idle_inc;
  logic [INDEX_W-1:0]    count_inc;
  logic [BYTE_W-1:0]     pbyte;

  // Saturating tick count, next byte position and reassembled byte
  assign idle_inc  = (idle_ticks == TICKS_MAX) ? idle_ticks : idle_ticks + 1'b1;
  assign count_inc = byte_count + 1'b1;
  assign pbyte     = {prev_sample[1:0], sample[SAMPLE_W-1:2]};

  // Next state and result for one accepted transaction
  always_comb begin
    state_next        = state;
    prev_sample_next  = prev_sample;
    running_xor_next  = running_xor;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    idle_ticks_next   = idle_ticks;
    res               = '0;
    if (accept) begin
      case (op_t'(op))
        OP_ARM: begin
          state_next        = RX_HUNT;
          prev_sample_next  = '0;
          running_xor_next  = '0;
          byte_count_next   = '0;
          frame_length_next = BASE_LENGTH;
          idle_ticks_next   = '0;
        end
        OP_TICK: begin
          if (state != RX_INACTIVE) begin
            idle_ticks_next = idle_inc;
            if (idle_inc > timeout_ticks) begin
              state_next = RX_INACTIVE;
              res.valid  = 1'b1;
              res.status = ST_TIMEOUT;
            end
          end
        end
        OP_SAMPLE: begin
          if (state != RX_INACTIVE) begin
            idle_ticks_next = '0;
            if (state == RX_HUNT) begin
              if ((sample & START_MASK) == START_PATTERN) begin
                state_next        = RX_DATA;
                byte_count_next   = '0;
                frame_length_next = BASE_LENGTH;
                running_xor_next  = '0;
                prev_sample_next  = sample;
              end else begin
                res.valid  = 1'b1;
                res.status = ST_SYNC_ERR;
              end
            end else begin
              prev_sample_next = sample;
              byte_count_next  = count_inc;
              res.valid        = 1'b1;
              res.pbyte        = pbyte;
              res.index        = byte_count;
              res.status       = ST_BYTE;
              running_xor_next = running_xor ^ pbyte;
              if (count_inc == INDEX_W'(1)) begin
                // header byte holds the word count
                frame_length_next = BASE_LENGTH + {1'b0, pbyte, 2'b00};
              end else if (count_inc == frame_length) begin
                // checksum byte closes the frame
                state_next       = RX_INACTIVE;
                running_xor_next = running_xor;
                res.status       = (running_xor == pbyte) ? ST_SUM_OK : ST_SUM_BAD;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= RX_INACTIVE;
      prev_sample   <= '0;
      running_xor   <= '0;
      byte_count    <= '0;
      frame_length  <= BASE_LENGTH;
      idle_ticks    <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      state        <= state_next;
      prev_sample  <= prev_sample_next;
      running_xor  <= running_xor_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      idle_ticks   <= idle_ticks_next;
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

`ifndef SYNTH
  // Inside a frame the position never reaches the frame length
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == RX_DATA) |-> (byte_count < frame_length))
    else $error("byte_count reached frame_length inside a frame");

  // While hunting for a start no bytes have been counted
  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    (state == RX_HUNT) |-> (byte_count == '0))
    else $error("byte_count not clear while hunting");

  // An inactive receiver gives no result for samples or ticks
  a_inactive_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && state == RX_INACTIVE) |-> !res.valid)
    else $error("result produced while inactive");

  // A frame-ending result leaves the receiver inactive
  a_end_inactive: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == ST_SUM_OK || res.status == ST_SUM_BAD
                   || res.status == ST_TIMEOUT)) |=> (state == RX_INACTIVE))
    else $error("receiver still active after frame end");
`endif

endmodule

FILE: design/sfrd_out_stage.sv
// Output result register with stream handshake.
`timescale 1ns / 1ps

module sfrd_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  sfrd_pkg::result_t                 res,
  output logic                              can_load,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sfrd_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [sfrd_pkg::STATUS_W-1:0]     m_tuser
);
  import sfrd_pkg::*;

  result_t held;

  // Space for a new result when empty or draining this cycle
  assign can_load = !m_tvalid || m_tready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res.valid) begin
      held <= res;
    end
  end

  assign m_tdata = {(OUT_DATA_W - BYTE_W - INDEX_W)'(0), held.index, held.pbyte};
  assign m_tuser = held.status;

endmodule

FILE: design/serial_frame_rx_deframer.sv
// Top level of the serial frame receive deframer.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser = op, s_tdata = sample
//  m_*      out  m_tvalid/m_tready  m_tuser = status, m_tdata = byte, index
//  cfg_*    in   cfg_valid/cfg_ready cfg_data = timeout_ticks
//
// One transaction per cycle while s_tready is high; any result appears on m_* in the cycle after accept.
// The rate is set by the single result register: s_tready drops only while a
// result is held and m_tready is low.
// Reset is synchronous: receiver inactive, timeout_ticks 5000.
// Config writes are always taken (cfg_ready is high).
`timescale 1ns / 1ps

module serial_frame_rx_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] frame byte, [18:8] byte_index, [23:19] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // [15:0] timeout_ticks
);
  import sfrd_pkg::*;

  result_t res;
  logic    can_load;
  logic    accept;

  assign s_tready  = can_load;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Receiver state and result logic
  sfrd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (s_tuser),
    .sample   (s_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  // Result register
  sfrd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the serial frame receive deframer.
`timescale 1ns / 1ps

module testbench;
  import sfrd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;   // op code the block must ignore
  localparam int STALL_LIMIT = 2000;         // cycles with no transaction at all

  // One deframer result as seen on the output stream
  typedef struct {
    status_t            status;
    logic [BYTE_W-1:0]  pbyte;
    logic [INDEX_W-1:0] index;
  } rx_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] sample
  logic [1:0]  s_tuser = '0;    // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] frame byte, [18:8] byte_index, [23:19] zero
  logic [2:0]  m_tuser;         // [2:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;   // [15:0] timeout_ticks

  int err_count = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  bit idle_en = 1'b1;

  // Deframer state mirrored by the predictor
  logic [TICKS_W-1:0]  timeout_cfg = TIMEOUT_RESET;
  bit                  rx_armed = 1'b0;
  bit                  rx_in_frame = 1'b0;
  logic [SAMPLE_W-1:0] last_sample = '0;
  logic [BYTE_W-1:0]   frame_xor = '0;
  logic [INDEX_W-1:0]  bytes_seen = '0;
  logic [INDEX_W-1:0]  frame_len = BASE_LENGTH;
  logic [TICKS_W-1:0]  idle_count = '0;

  rx_result_t pending_results[$];

  serial_frame_rx_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic queue_result(input status_t st, input logic [BYTE_W-1:0] pb,
                              input logic [INDEX_W-1:0] idx);
    pending_results.push_back('{st, pb, idx});
  endtask

  // Predictor: advance the mirrored deframer by one accepted transaction
  task automatic deframe_step(input logic [1:0] op, input logic [SAMPLE_W-1:0] smp);
    logic [BYTE_W-1:0]  pb;
    logic [INDEX_W-1:0] idx;
    if (op == OP_ARM) begin
      rx_armed    = 1'b1;
      rx_in_frame = 1'b0;
      last_sample = '0;
      frame_xor   = '0;
      bytes_seen  = '0;
      frame_len   = BASE_LENGTH;
      idle_count  = '0;
    end else if (rx_armed && op == OP_TICK) begin
      if (idle_count != TICKS_MAX) idle_count++;
      if (idle_count > timeout_cfg) begin
        rx_armed    = 1'b0;
        rx_in_frame = 1'b0;
        queue_result(ST_TIMEOUT, '0, '0);
      end
    end else if (rx_armed && op == OP_SAMPLE) begin
      idle_count = '0;
      if (!rx_in_frame) begin
        if ((smp & START_MASK) == START_PATTERN) begin
          rx_in_frame = 1'b1;
          bytes_seen  = '0;
          frame_len   = BASE_LENGTH;
          frame_xor   = '0;
          last_sample = smp;
        end else begin
          queue_result(ST_SYNC_ERR, '0, '0);
        end
      end else begin
        // low 2 bits of previous sample on top, top 6 bits of this one below
        pb = ((last_sample & LOW_MASK) << 6) | ((smp & START_MASK) >> 2);
        idx = bytes_seen;
        last_sample = smp;
        bytes_seen = bytes_seen + 11'd1;
        if (bytes_seen == 11'd1) begin
          frame_len = BASE_LENGTH + {1'b0, pb, 2'b00};
        end else if (bytes_seen == frame_len) begin
          rx_armed    = 1'b0;
          rx_in_frame = 1'b0;
          queue_result((frame_xor == pb) ? ST_SUM_OK : ST_SUM_BAD, pb, idx);
        end
        if (rx_in_frame) begin
          frame_xor = frame_xor ^ pb;
          queue_result(ST_BYTE, pb, idx);
        end
      end
    end
  endtask

  // Send one input transaction; s_tvalid is left high for a following item
  task automatic send_item(input logic [1:0] op, input logic [SAMPLE_W-1:0] smp);
    while (idle_en && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    deframe_step(op, smp);
  endtask

  // Build a frame of 5 + 4*count bytes and send it as line samples.
  // cut_at >= 0 stops after that many data samples; tick_pct mixes in ticks.
  task automatic send_line_frame(input logic [7:0] count, input bit good_sum,
                                 input int cut_at, input int tick_pct);
    logic [7:0] fbytes[$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [1:0] tail;
    int len;
    len = 5 + 4 * count;
    sum = count;
    fbytes.push_back(count);
    for (int i = 1; i < len - 1; i++) begin
      b = 8'($urandom_range(0, 255));
      fbytes.push_back(b);
      sum = sum ^ b;
    end
    fbytes.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    tail = 2'($urandom_range(0, 3));
    send_item(OP_SAMPLE, {START_PATTERN[7:2], fbytes[0][7:6]});
    for (int i = 0; i < len && i != cut_at; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      send_item(OP_SAMPLE, {fbytes[i][5:0], (i + 1 < len) ? fbytes[i+1][7:6] : tail});
    end
  endtask

  // Stop sending, wait for every pending result, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TICKS_W-1:0] ticks);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    timeout_cfg = ticks;
    cfg_valid <= 1'b0;
  endtask

  // Samples, ticks and the unused op before the first arm do nothing
  task automatic test_inactive_ignored();
    send_item(OP_SAMPLE, START_PATTERN);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_UNUSED, 8'hFF);
  endtask

  // Non-start samples while hunting, then a minimal frame
  task automatic test_sync_errors();
    send_item(OP_ARM, 8'h00);
    send_item(OP_UNUSED, 8'h84);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_SAMPLE, 8'h83);
    send_item(OP_SAMPLE, 8'h88);
    send_line_frame(8'd0, 1'b1, -1, 0);
    send_item(OP_SAMPLE, 8'h84);    // finished, so ignored
  endtask

  // Bad checksum, and re-arm in the middle of a frame
  task automatic test_frames();
    send_item(OP_ARM, 8'hFF);
    send_line_frame(8'd0, 1'b0, -1, 0);
    send_item(OP_ARM, 8'h00);
    send_line_frame(8'd1, 1'b1, 3, 0);
    send_item(OP_ARM, 8'h00);
    send_line_frame(8'd2, 1'b1, -1, 0);
  endtask

  // Reset limit of 5000 ticks outlasts a short idle stretch
  task automatic test_timeout_default();
    send_item(OP_ARM, 8'h00);
    repeat (100) send_item(OP_TICK, 8'h00);
    send_line_frame(8'd0, 1'b1, -1, 0);
  endtask

  // Limit of one tick and the largest limit; a sample clears the idle count
  task automatic test_timeout_limits();
    write_timeout(16'd1);
    send_item(OP_ARM, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_ARM, 8'h00);
    send_item(OP_SAMPLE, 8'h86);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SAMPLE, 8'h55);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_SAMPLE, 8'h12);
    // largest limit: ticks do not end the reception
    write_timeout(TICKS_MAX);
    send_item(OP_ARM, 8'h00);
    repeat (100) send_item(OP_TICK, 8'h00);
    send_line_frame(8'd1, 1'b1, -1, 0);
  endtask

  // Longest frame reaches byte index 1024
  task automatic test_largest_frame();
    send_item(OP_ARM, 8'h00);
    send_line_frame(8'd255, 1'b1, -1, 5);
  endtask

  task automatic random_burst();
    int pick;
    int cnt;
    int n;
    pick = $urandom_range(0, 99);
    cnt = ($urandom_range(0, 99) == 0) ? $urandom_range(4, 255) : $urandom_range(0, 3);
    n = (timeout_cfg <= 16) ? timeout_cfg + 1 : $urandom_range(1, 4);
    if (pick < 70) begin
      // well-formed frame, sometimes after line noise
      send_item(OP_ARM, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) send_item(OP_SAMPLE, 8'($urandom_range(0, 255)));
      send_line_frame(8'(cnt), $urandom_range(0, 4) != 0, -1, 10);
    end else if (pick < 80) begin
      // broken frame that stalls
      send_item(OP_ARM, 8'($urandom_range(0, 255)));
      send_line_frame(8'(cnt), 1'b1, int'($urandom_range(0, 4)), 10);
      repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 5))
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end else begin
      send_item(OP_ARM, 8'($urandom_range(0, 255)));
      repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // Random traffic under several limits, one phase without idling
  task automatic test_random_traffic();
    logic [TICKS_W-1:0] phase_ticks[4];
    int stop_at;
    phase_ticks[0] = 16'($urandom_range(2, 6));
    phase_ticks[1] = 16'd1;
    phase_ticks[2] = TICKS_MAX;
    phase_ticks[3] = 16'($urandom_range(7, 65535));
    for (int p = 0; p < 4; p++) begin
      write_timeout(phase_ticks[p]);
      idle_en = (p != 1);
      stop_at = items_sent + 200;
      while (items_sent < stop_at) random_burst();
    end
    idle_en = 1'b1;
  endtask

  // Output side: random back-pressure
  always @(posedge clk) begin
    m_tready <= !(idle_en && $urandom_range(0, 99) < 28);
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(m_tuser), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status)
          report_mismatch("status", int'(m_tuser), int'(want.status));
        if (m_tdata[7:0] != want.pbyte)
          report_mismatch("frame byte", int'(m_tdata[7:0]), int'(want.pbyte));
        if (m_tdata[18:8] != want.index)
          report_mismatch("byte_index", int'(m_tdata[18:8]), int'(want.index));
        if (m_tdata[23:19] != '0)
          report_mismatch("tdata padding", int'(m_tdata[23:19]), 0);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_inactive_ignored();
    test_sync_errors();
    test_frames();
    test_timeout_default();
    test_timeout_limits();
    test_largest_frame();
    test_random_traffic();
    settle();
    if (pending_results.size() != 0)
      report_mismatch("results left pending", pending_results.size(), 0);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/sfrd_pkg.sv
design/sfrd_core.sv
design/sfrd_out_stage.sv
design/serial_frame_rx_deframer.sv
tb/sv/testbench.sv
